// File: hw/rtl/seven_stop_color_ramp_top_defines.svh
// Assertion macros for the seven-stop color ramp.
// Included by the top level, which checks its own logic; needs clk and rst in scope.
`ifndef SEVEN_STOP_COLOR_RAMP_TOP_DEFINES_SVH
`define SEVEN_STOP_COLOR_RAMP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset.
`define CRMP_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("color ramp assertion failed");

// Consequence holds in the same cycle as the antecedent.
`define CRMP_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("color ramp assertion failed");

// Consequence holds in the cycle after the antecedent.
`define CRMP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("color ramp assertion failed");

`else

`define CRMP_ASSERT_HOLDS(lbl, cond)
`define CRMP_ASSERT_IMPL(lbl, pre, post)
`define CRMP_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// File: hw/rtl/crmp_pkg.sv
// Shared types and constants of the seven-stop color ramp.
// Used by the division cells, the channel interpolators and the top level.
package crmp_pkg;

  // Position scale across the whole ramp and per segment.
  localparam int unsigned POS_SCALE = 6000;
  localparam int unsigned SEG_SCALE = 1000;
  // Quotient bits: position stays below POS_SCALE < 2**13.
  localparam int unsigned POS_BITS  = 13;
  localparam int unsigned SEG_BITS  = 3;
  localparam int unsigned FRAC_BITS = 10;

  // Color stops and channels.
  localparam int unsigned STOP_COUNT = 7;
  localparam int unsigned CH_COUNT   = 3;
  localparam int unsigned CH_RED     = 0;
  localparam int unsigned CH_GREEN   = 1;
  localparam int unsigned CH_BLUE    = 2;

  localparam logic [7:0] STOP_RGB [STOP_COUNT][CH_COUNT] = '{
    '{8'd64,  8'd224, 8'd208},  // turquoise
    '{8'd173, 8'd216, 8'd230},  // light blue
    '{8'd0,   8'd200, 8'd0  },  // green
    '{8'd255, 8'd220, 8'd0  },  // yellow
    '{8'd255, 8'd140, 8'd0  },  // orange
    '{8'd220, 8'd20,  8'd20 },  // red
    '{8'd148, 8'd0,   8'd211}   // violet
  };

  // Divide by SEG_SCALE as multiply by ceil(2**28/1000) and shift; exact for
  // products below 493000, and |delta| * frac stays below 255000.
  localparam int unsigned P_BITS      = 18;
  localparam int unsigned RECIP_BITS  = 19;
  localparam int unsigned PROD_BITS   = P_BITS + RECIP_BITS;
  localparam int unsigned RECIP       = 268436;
  localparam int unsigned RECIP_SHIFT = 28;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_WINDOW_LOW    = 2'd0;
  localparam logic [1:0] REG_WINDOW_HIGH   = 2'd1;
  localparam logic [1:0] REG_REVERSE_SENSE = 2'd2;
  localparam int         LOW_RESET         = 0;
  localparam int         HIGH_RESET        = 365;
  // Register width floor so that HIGH_RESET is representable.
  localparam int unsigned MIN_REG_BITS     = 10;

  // Saturation flags that ride along with each transaction.
  typedef struct packed {
    logic first;  // clamp to the first stop
    logic last;   // clamp to the last stop
  } tag_t;

endpackage

// File: hw/rtl/crmp_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit per cell.
// Depends on crmp_pkg (POS_BITS, tag_t).
module crmp_div_cell #(
  parameter int RW    = 16,
  parameter int SHIFT = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            up_valid,
  input  logic [RW+crmp_pkg::POS_BITS-1:0] up_rem,
  input  logic [RW-1:0]                   up_den,
  input  logic [crmp_pkg::POS_BITS-1:0]   up_quot,
  input  crmp_pkg::tag_t                  up_tag,
  output logic                            valid,
  output logic [RW+crmp_pkg::POS_BITS-1:0] rem,
  output logic [RW-1:0]                   den,
  output logic [crmp_pkg::POS_BITS-1:0]   quot,
  output crmp_pkg::tag_t                  tag
);

  localparam int DW = RW + crmp_pkg::POS_BITS;

  logic [DW-1:0]                 den_sh;
  logic                          take;
  logic [DW-1:0]                 rem_next;
  logic [crmp_pkg::POS_BITS-1:0] quot_next;

  // Trial subtract of the shifted divisor.
  always_comb begin
    den_sh    = DW'(up_den) << SHIFT;
    take      = (up_rem >= den_sh);
    rem_next  = take ? (up_rem - den_sh) : up_rem;
    quot_next = up_quot;
    quot_next[SHIFT] = take;
  end

  // Advance the valid bit with the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      den  <= up_den;
      quot <= quot_next;
      tag  <= up_tag;
    end
  end

endmodule

// File: hw/rtl/crmp_chan.sv
// One color channel: interpolates between neighboring stops in two stages.
// Depends on crmp_pkg (stop table, reciprocal constants).
module crmp_chan #(
  parameter int CHAN = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [crmp_pkg::SEG_BITS-1:0]  seg,
  input  logic [crmp_pkg::FRAC_BITS-1:0] frac,
  output logic [7:0]                     level
);

  logic [7:0]                      a_lvl;
  logic [7:0]                      b_lvl;
  logic                            neg_next;
  logic [7:0]                      mag_next;
  logic [crmp_pkg::P_BITS-1:0]     p_next;

  logic [crmp_pkg::P_BITS-1:0]     p1;
  logic                            neg1;
  logic [7:0]                      a1;
  logic [crmp_pkg::PROD_BITS-1:0]  prod2;
  logic                            neg2;
  logic [7:0]                      a2;
  logic [7:0]                      step;

  // Look up the two stops and scale the step magnitude by the fraction.
  always_comb begin
    a_lvl    = crmp_pkg::STOP_RGB[seg][CHAN];
    b_lvl    = crmp_pkg::STOP_RGB[crmp_pkg::SEG_BITS'(seg + 1'b1)][CHAN];
    neg_next = (b_lvl < a_lvl);
    mag_next = neg_next ? (a_lvl - b_lvl) : (b_lvl - a_lvl);
    p_next   = crmp_pkg::P_BITS'(mag_next) * crmp_pkg::P_BITS'(frac);
  end

  // Stage one: product, then stage two: multiply by the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= p_next;
      neg1  <= neg_next;
      a1    <= a_lvl;
      prod2 <= crmp_pkg::PROD_BITS'(p1) *
               crmp_pkg::PROD_BITS'(crmp_pkg::RECIP);
      neg2  <= neg1;
      a2    <= a1;
    end
  end

  // Quotient truncates toward zero since the sign is applied afterward.
  always_comb begin
    step  = prod2[crmp_pkg::RECIP_SHIFT +: 8];
    level = neg2 ? (a2 - step) : (a2 + step);
  end

endmodule

// File: hw/rtl/seven_stop_color_ramp_top.sv
// Seven-stop color ramp: maps a signed sample onto a rainbow of seven stops.
// Depends on crmp_pkg, crmp_div_cell, crmp_chan and the assertion header.
//
// One transaction is taken every clock unless sample_stall is high, and each
// yields one color through the prepare register (mirror and clamp against the
// window), the registers that form (value - low) * 6000, the divider cells
// (one quotient bit per cell), the segment split, each channel interpolator
// and the output register. The divider chain is the longest part; throughput
// is one color per clock while nothing stalls. A one-entry skid register
// behind the output register absorbs a stall; sample_stall is that skid's
// full flag, so the whole pipeline holds while it is occupied. The window
// registers may only be written while no transaction is in flight.

`include "seven_stop_color_ramp_top_defines.svh"

module seven_stop_color_ramp_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic signed [VALUE_BITS-1:0] sample_value,
  output logic                         color_valid,
  input  logic                         color_stall,
  output logic [7:0]                   red_level,
  output logic [7:0]                   green_level,
  output logic [7:0]                   blue_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [VALUE_BITS-1:0]        cfg_data
);

  localparam int RW  = (VALUE_BITS < crmp_pkg::MIN_REG_BITS) ?
                       crmp_pkg::MIN_REG_BITS : VALUE_BITS;
  localparam int XW  = RW + 2;
  localparam int PB  = crmp_pkg::POS_BITS;
  localparam int DW  = RW + PB;
  localparam int T1W = RW + 9;
  localparam int T2W = RW + 4;
  localparam int NC  = crmp_pkg::CH_COUNT;

  // Configuration registers.
  logic signed [RW-1:0] window_low;
  logic signed [RW-1:0] window_high;
  logic                 reverse_sense;

  // Global pipeline advance.
  logic en;

  // Prepare stage.
  logic signed [XW-1:0] v_x, lo_x, hi_x, m_x;
  crmp_pkg::tag_t       tag_next;
  logic                 v1;
  logic [RW-1:0]        num1, den1;
  crmp_pkg::tag_t       tag1;

  // Multiply by 6000 = 16 * (256 + 128 - 8 - 1).
  logic                 v2;
  logic [T1W-1:0]       t1_2;
  logic [T2W-1:0]       t2_2;
  logic [RW-1:0]        den2;
  crmp_pkg::tag_t       tag2;
  logic                 v3;
  logic [DW-1:0]        dvd3;
  logic [RW-1:0]        den3;
  crmp_pkg::tag_t       tag3;

  // Divider chain taps.
  logic                 vld_c  [PB+1];
  logic [DW-1:0]        rem_c  [PB+1];
  logic [RW-1:0]        den_c  [PB+1];
  logic [PB-1:0]        quot_c [PB+1];
  crmp_pkg::tag_t       tag_c  [PB+1];
  logic                 div_live;

  // Segment split stage.
  logic [crmp_pkg::SEG_BITS-1:0]  seg_next;
  logic [PB-1:0]                  base_next;
  logic                           vs;
  logic [crmp_pkg::SEG_BITS-1:0]  seg_s;
  logic [crmp_pkg::FRAC_BITS-1:0] frac_s;
  crmp_pkg::tag_t                 tag_s;

  // Flags beside the channel stages.
  logic           vm1, vm2;
  crmp_pkg::tag_t tagm1, tagm2;

  // Results and output buffering.
  logic [7:0] lvl      [NC];
  logic [7:0] res      [NC];
  logic       arrive;
  logic       skid_valid;
  logic [7:0] skid_lvl [NC];

  assign cfg_ready    = 1'b1;
  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  // Write configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_low    <= RW'(crmp_pkg::LOW_RESET);
      window_high   <= RW'(crmp_pkg::HIGH_RESET);
      reverse_sense <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crmp_pkg::REG_WINDOW_LOW:    window_low    <= RW'($signed(cfg_data));
        crmp_pkg::REG_WINDOW_HIGH:   window_high   <= RW'($signed(cfg_data));
        crmp_pkg::REG_REVERSE_SENSE: reverse_sense <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Mirror inside the window and classify against its ends.
  always_comb begin
    v_x  = XW'(sample_value);
    lo_x = XW'(window_low);
    hi_x = XW'(window_high);
    m_x  = reverse_sense ? (lo_x + hi_x - v_x) : v_x;
    tag_next.first = (hi_x <= lo_x) || (m_x <= lo_x);
    tag_next.last  = !tag_next.first && (m_x >= hi_x);
  end

  // Advance valid bits of the stages kept here.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      vs  <= 1'b0;
      vm1 <= 1'b0;
      vm2 <= 1'b0;
    end else if (en) begin
      v1  <= sample_valid;
      v2  <= v1;
      v3  <= v2;
      vs  <= vld_c[PB];
      vm1 <= vs;
      vm2 <= vm1;
    end
  end

  // Prepare, then scale the numerator by the position scale.
  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= RW'(m_x - lo_x);
      den1 <= RW'(hi_x - lo_x);
      tag1 <= tag_next;
      t1_2 <= (T1W'(num1) << 8) + (T1W'(num1) << 7);
      t2_2 <= (T2W'(num1) << 3) + T2W'(num1);
      den2 <= den1;
      tag2 <= tag1;
      dvd3 <= DW'(t1_2 - T1W'(t2_2)) << 4;
      den3 <= den2;
      tag3 <= tag2;
    end
  end

  // Feed the divider chain, most significant quotient bit first.
  assign vld_c[0]  = v3;
  assign rem_c[0]  = dvd3;
  assign den_c[0]  = den3;
  assign quot_c[0] = '0;
  assign tag_c[0]  = tag3;

  for (genvar i = 0; i < PB; i++) begin : g_div
    crmp_div_cell #(
      .RW    (RW),
      .SHIFT (PB - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .up_valid (vld_c[i]),
      .up_rem   (rem_c[i]),
      .up_den   (den_c[i]),
      .up_quot  (quot_c[i]),
      .up_tag   (tag_c[i]),
      .valid    (vld_c[i+1]),
      .rem      (rem_c[i+1]),
      .den      (den_c[i+1]),
      .quot     (quot_c[i+1]),
      .tag      (tag_c[i+1])
    );
  end

  // Split the position into segment and thousandths.
  always_comb begin
    seg_next  = '0;
    base_next = '0;
    for (int k = 1; k < crmp_pkg::STOP_COUNT - 1; k++) begin
      if (quot_c[PB] >= PB'(k * crmp_pkg::SEG_SCALE)) begin
        seg_next  = crmp_pkg::SEG_BITS'(k);
        base_next = PB'(k * crmp_pkg::SEG_SCALE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_s  <= seg_next;
      frac_s <= crmp_pkg::FRAC_BITS'(quot_c[PB] - base_next);
      tag_s  <= tag_c[PB];
      tagm1  <= tag_s;
      tagm2  <= tagm1;
    end
  end

  // Interpolate each channel and apply the window clamps.
  for (genvar c = 0; c < NC; c++) begin : g_chan
    crmp_chan #(
      .CHAN (c)
    ) u_chan (
      .clk   (clk),
      .en    (en),
      .seg   (seg_s),
      .frac  (frac_s),
      .level (lvl[c])
    );

    assign res[c] = tagm2.first ? crmp_pkg::STOP_RGB[0][c] :
                    tagm2.last  ? crmp_pkg::STOP_RGB[crmp_pkg::STOP_COUNT-1][c] :
                    lvl[c];
  end

  assign arrive = vm2 && en;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!color_valid || !color_stall) begin
      color_valid <= skid_valid || arrive;
      skid_valid  <= 1'b0;
    end else if (arrive) begin
      skid_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!color_valid || !color_stall) begin
      if (skid_valid) begin
        red_level   <= skid_lvl[crmp_pkg::CH_RED];
        green_level <= skid_lvl[crmp_pkg::CH_GREEN];
        blue_level  <= skid_lvl[crmp_pkg::CH_BLUE];
      end else begin
        red_level   <= res[crmp_pkg::CH_RED];
        green_level <= res[crmp_pkg::CH_GREEN];
        blue_level  <= res[crmp_pkg::CH_BLUE];
      end
    end else if (arrive) begin
      skid_lvl <= res;
    end
  end

  // Unclamped transaction leaving the divider chain.
  assign div_live = vld_c[PB] && !tag_c[PB].first && !tag_c[PB].last;

  // Checks on the output buffering, the clamp flags and the divider chain.
  `CRMP_ASSERT_IMPL(a_skid_behind_out, skid_valid, color_valid)
  `CRMP_ASSERT_NEXT(a_skid_drains, skid_valid && !color_stall, !skid_valid)
  `CRMP_ASSERT_IMPL(a_tag_exclusive, vm2, !(tagm2.first && tagm2.last))
  `CRMP_ASSERT_IMPL(a_pos_range, div_live, quot_c[PB] < PB'(crmp_pkg::POS_SCALE))
  `CRMP_ASSERT_IMPL(a_rem_below_den, div_live, rem_c[PB] < DW'(den_c[PB]))

endmodule
